// ----- rtl/dqe_pkg.sv -----
`timescale 1ns / 1ps

package dqe_pkg;

  // One packet byte as it enters the block.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } in_item_t;

  // One result: a name character, or a single not-found marker.
  typedef struct packed {
    logic       found;
    logic       from_udp_offset;
    logic [7:0] name_char;
    logic [5:0] char_index;
    logic [5:0] name_length;
    logic       run_last;
  } out_item_t;

  // Write into a lane's name store.
  typedef struct packed {
    logic       en;
    logic [5:0] idx;
    logic [7:0] data;
  } name_wr_t;

  // Verdict of a lane, taken on its state after the current byte.
  typedef struct packed {
    logic       good;
    logic [5:0] name_length;
  } lane_stat_t;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_CAP  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  localparam logic [15:0] TCP_START = 16'd14;
  localparam logic [15:0] UDP_START = 16'd12;
  localparam logic [16:0] MIN_PKT_LEN = 17'd14;
  localparam logic [7:0] MAX_LABEL = 8'd63;
  localparam logic [6:0] MIN_CAPACITY = 7'd4;
  localparam logic [5:0] MIN_NAME_LEN = 6'd4;

  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_DOT   = 8'h2e;

  localparam logic REG_NAME_CAPACITY = 1'b0;

  function automatic logic is_upper(input logic [7:0] b);
    return (b >= 8'h41) && (b <= 8'h5a);
  endfunction

  function automatic logic char_ok(input logic [7:0] b);
    return ((b >= 8'h30) && (b <= 8'h39)) || ((b >= 8'h61) && (b <= 8'h7a)) ||
           is_upper(b) || (b == CH_DASH) || (b == CH_UNDER);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return is_upper(b) ? (b | 8'h20) : b;
  endfunction

endpackage

// ----- rtl/dns_qname_extractor.sv -----
`timescale 1ns / 1ps

// Channel   Ports                         Carries
// -------   ---------------------------   ----------------------------------------
// input     in_valid/in_ready/in_data     one packet byte plus end-of-packet flag
// output    out_valid/out_ready/out_data  one name character or a not-found marker
// config    psel/penable/pwrite/paddr/..  name_capacity at byte address 0
//
// Each packet byte is one transfer; each lane updates and writes its store on it from its start offset on.
// An end-of-packet byte with a usable name of n characters starts a run read from the chosen
// store at one result per cycle unless out_ready stalls it; each read goes through the read
// stage into the result register, and the input is held off until the final read is issued.
// Reset is synchronous and active low; it clears control state and sets name_capacity to 64.
// out_ready stalls hold the result and read stages; end-of-packet waits until both can take it.

module dns_qname_extractor #(
  parameter int NAME_MAX = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dqe_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dqe_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Characters a lane can hold; the name length field stops at 63.
  localparam int CAP_MAX = (NAME_MAX < 64) ? NAME_MAX : 64;
  localparam int AW      = $clog2(CAP_MAX);

  logic [6:0]          cap_r;
  logic [15:0]         pos_r;
  logic [16:0]         pkt_len;
  logic [6:0]          cap_clamped;
  logic [5:0]          limit;
  logic                in_xfer, clear, pkt_ok, found;
  logic                step_tcp, step_udp;
  logic                idle, out_room;
  logic                rd_en, rd_lane;
  logic [AW-1:0]       rd_addr;
  logic [7:0]          q_tcp, q_udp;
  dqe_pkg::name_wr_t   wr_tcp, wr_udp;
  dqe_pkg::lane_stat_t stat_tcp, stat_udp;

  // Configuration port: always ready, one register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == dqe_pkg::REG_NAME_CAPACITY) ? {25'd0, cap_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= 7'd64;
    end else if (psel && penable && pwrite && (paddr[2] == dqe_pkg::REG_NAME_CAPACITY)) begin
      cap_r <= pwdata[6:0];
    end
  end

  // The usable capacity is clamped between the minimum and the store size; the last slot is the
  // terminator, so the name itself stops one short.
  always_comb begin
    if (cap_r < dqe_pkg::MIN_CAPACITY) begin
      cap_clamped = dqe_pkg::MIN_CAPACITY;
    end else if (cap_r > 7'(CAP_MAX)) begin
      cap_clamped = 7'(CAP_MAX);
    end else begin
      cap_clamped = cap_r;
    end
  end
  assign limit = 6'(cap_clamped - 7'd1);

  // An end-of-packet byte needs room for its not-found result.
  assign in_ready = idle && (!in_data.end_of_packet || out_room);
  assign in_xfer  = in_valid && in_ready;
  assign clear    = in_xfer && in_data.end_of_packet;
  assign pkt_len  = {1'b0, pos_r} + 17'd1;
  assign step_tcp = in_xfer && (pos_r >= dqe_pkg::TCP_START);
  assign step_udp = in_xfer && (pos_r >= dqe_pkg::UDP_START);

  // Byte position saturates instead of wrapping on very long packets.
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      pos_r <= '0;
    end else if (in_xfer && (pos_r != 16'hffff)) begin
      pos_r <= pos_r + 16'd1;
    end
  end

  dqe_lane u_lane_tcp (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step_tcp),
    .clear     (clear),
    .data_byte (in_data.data_byte),
    .pkt_len   (pkt_len),
    .limit     (limit),
    .wr        (wr_tcp),
    .stat      (stat_tcp)
  );

  dqe_lane u_lane_udp (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step_udp),
    .clear     (clear),
    .data_byte (in_data.data_byte),
    .pkt_len   (pkt_len),
    .limit     (limit),
    .wr        (wr_udp),
    .stat      (stat_udp)
  );

  dqe_ram #(.DEPTH(CAP_MAX)) u_store_tcp (
    .clk   (clk),
    .we    (wr_tcp.en),
    .waddr (wr_tcp.idx[AW-1:0]),
    .wdata (wr_tcp.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (q_tcp)
  );

  dqe_ram #(.DEPTH(CAP_MAX)) u_store_udp (
    .clk   (clk),
    .we    (wr_udp.en),
    .waddr (wr_udp.idx[AW-1:0]),
    .wdata (wr_udp.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (q_udp)
  );

  // The offset-14 lane wins when both lanes hold a usable name.
  assign pkt_ok = (pkt_len >= dqe_pkg::MIN_PKT_LEN) && (cap_r >= dqe_pkg::MIN_CAPACITY);
  assign found  = pkt_ok && (stat_tcp.good || stat_udp.good);

  dqe_emit #(.AW(AW)) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (clear && found),
    .start_lane (!stat_tcp.good),
    .start_len  (stat_tcp.good ? stat_tcp.name_length : stat_udp.name_length),
    .nf_load    (clear && !found),
    .idle       (idle),
    .out_room   (out_room),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_lane    (rd_lane),
    .rd_q       (rd_lane ? q_udp : q_tcp),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ----- rtl/dqe_ram.sv -----
`timescale 1ns / 1ps

module dqe_ram #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/dqe_lane.sv -----
`timescale 1ns / 1ps

module dqe_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                clear,
  input  logic [7:0]          data_byte,
  input  logic [16:0]         pkt_len,
  input  logic [5:0]          limit,
  output dqe_pkg::name_wr_t   wr,
  output dqe_pkg::lane_stat_t stat
);

  logic [1:0]  status_r, status_nxt;
  logic [5:0]  remain_r, remain_nxt;
  logic [16:0] end_pos_r, end_pos_nxt;
  logic [5:0]  len_r, len_nxt;
  logic        dot_r, dot_nxt;
  logic        put;
  logic [7:0]  put_ch;
  logic        stopped;

  always_comb begin
    status_nxt  = status_r;
    remain_nxt  = remain_r;
    end_pos_nxt = end_pos_r;
    len_nxt     = len_r;
    dot_nxt     = dot_r;
    put         = 1'b0;
    put_ch      = dqe_pkg::CH_DOT;
    stopped     = 1'b0;
    if (step && (status_r == dqe_pkg::ST_RUN)) begin
      if (len_r >= limit) begin
        status_nxt = dqe_pkg::ST_CAP;
      end else begin
        if (remain_r == 6'd0) begin
          if (data_byte == 8'd0) begin
            status_nxt = dqe_pkg::ST_DONE;
            stopped    = 1'b1;
          end else if (data_byte > dqe_pkg::MAX_LABEL) begin
            status_nxt = dqe_pkg::ST_BAD;
            stopped    = 1'b1;
          end else begin
            end_pos_nxt = pkt_len + {9'd0, data_byte};
            remain_nxt  = data_byte[5:0];
            put         = (len_r != 6'd0);
          end
        end else begin
          if (!dqe_pkg::char_ok(data_byte)) begin
            status_nxt = dqe_pkg::ST_BAD;
            stopped    = 1'b1;
          end else begin
            put        = 1'b1;
            put_ch     = dqe_pkg::to_lower(data_byte);
            remain_nxt = remain_r - 6'd1;
          end
        end
        if (put) begin
          len_nxt = len_r + 6'd1;
        end
        dot_nxt = dot_r | (put && (put_ch == dqe_pkg::CH_DOT));
        if (!stopped && (len_nxt >= limit)) begin
          status_nxt = dqe_pkg::ST_CAP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      status_r  <= dqe_pkg::ST_RUN;
      remain_r  <= '0;
      end_pos_r <= '0;
      len_r     <= '0;
      dot_r     <= 1'b0;
    end else begin
      status_r  <= status_nxt;
      remain_r  <= remain_nxt;
      end_pos_r <= end_pos_nxt;
      len_r     <= len_nxt;
      dot_r     <= dot_nxt;
    end
  end

  assign wr.en   = put;
  assign wr.idx  = len_r;
  assign wr.data = put_ch;

  // A lane that has not finished its name must not have a label cut by the
  // packet end.
  assign stat.good = (status_nxt != dqe_pkg::ST_BAD) &&
                     !((status_nxt != dqe_pkg::ST_DONE) && (end_pos_nxt > pkt_len)) &&
                     (len_nxt >= dqe_pkg::MIN_NAME_LEN) && dot_nxt;
  assign stat.name_length = len_nxt;

endmodule

// ----- rtl/dqe_emit.sv -----
`timescale 1ns / 1ps

module dqe_emit #(
  parameter int AW = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                start_lane,
  input  logic [5:0]          start_len,
  input  logic                nf_load,
  output logic                idle,
  output logic                out_room,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  output logic                rd_lane,
  input  logic [7:0]          rd_q,
  output logic                out_valid,
  input  logic                out_ready,
  output dqe_pkg::out_item_t  out_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic               state_r, state_nxt;
  logic [5:0]         k_r, k_nxt;
  logic [5:0]         n_r, n_nxt;
  logic               lane_r, lane_nxt;
  logic               rd_valid_r, rd_valid_nxt;
  logic [5:0]         rd_k_r, rd_k_nxt;
  logic               rd_last_r, rd_last_nxt;
  logic               out_valid_r, out_valid_nxt;
  dqe_pkg::out_item_t out_data_r, out_data_nxt;
  logic               out_free, move, issue, issue_last;

  assign out_free   = !out_valid_r || out_ready;
  assign move       = rd_valid_r && out_free;
  assign issue      = (state_r == ST_EMIT) && (!rd_valid_r || move);
  assign issue_last = (k_r == (n_r - 6'd1));

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    lane_nxt      = lane_r;
    rd_valid_nxt  = rd_valid_r;
    rd_k_nxt      = rd_k_r;
    rd_last_nxt   = rd_last_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (start) begin
      state_nxt = ST_EMIT;
      k_nxt     = '0;
      n_nxt     = start_len;
      lane_nxt  = start_lane;
    end

    if (issue) begin
      rd_valid_nxt = 1'b1;
      rd_k_nxt     = k_r;
      rd_last_nxt  = issue_last;
      k_nxt        = k_r + 6'd1;
      if (issue_last) begin
        state_nxt = ST_IDLE;
      end
    end else if (move) begin
      rd_valid_nxt = 1'b0;
    end

    if (move) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{found: 1'b1, from_udp_offset: lane_r, name_char: rd_q,
                        char_index: rd_k_r, name_length: n_r, run_last: rd_last_r};
    end else if (nf_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{found: 1'b0, from_udp_offset: 1'b0, name_char: 8'd0,
                        char_index: 6'd0, name_length: 6'd0, run_last: 1'b1};
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    k_r        <= k_nxt;
    n_r        <= n_nxt;
    lane_r     <= lane_nxt;
    rd_k_r     <= rd_k_nxt;
    rd_last_r  <= rd_last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign idle      = (state_r == ST_IDLE);
  assign out_room  = !rd_valid_r && out_free;
  assign rd_en     = issue;
  assign rd_addr   = k_r[AW-1:0];
  assign rd_lane   = lane_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_index_in_name: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.found |-> out_data_r.char_index < out_data_r.name_length)
    else $error("character index beyond name length");

  a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.found |->
      (out_data_r.run_last == (out_data_r.char_index == (out_data_r.name_length - 6'd1))))
    else $error("run_last does not mark the final character");

  a_emit_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> n_r >= dqe_pkg::MIN_NAME_LEN)
    else $error("emitting a name that is too short");

  a_read_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rd_valid_r) |-> $past(state_r) == ST_EMIT)
    else $error("name store read outside of an emission run");

endmodule
